FILE: rtl/core/hklt_pkg.sv
package hklt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Depth of the queue between the hashing front end and the table engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths of the words on the ports.
  localparam int HASH_W  = 32;
  localparam int ENTRY_W = 8;

  // Command codes on the request word.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Kind codes on the response word.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Request word: one key byte or a clear command.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } req_word_t;

  // Response word.
  typedef struct packed {
    logic [1:0]         kind;
    logic               hit;
    logic [ENTRY_W-1:0] entry_index;
    logic [HASH_W-1:0]  key_hash;
    logic               table_full;
  } rsp_word_t;

  // Table operation handed from the front end to the table engine.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR
  } job_op_t;

  typedef struct packed {
    job_op_t           op;
    logic [HASH_W-1:0] hash;
  } job_t;

endpackage

FILE: rtl/core/hklt_front.sv
module hklt_front
  import hklt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      job_valid,
  input  logic      job_ready,
  output job_t      job
);

  localparam int MIX_SHL = 10;
  localparam int MIX_SHR = 6;
  localparam int FIN_SHL_A = 3;
  localparam int FIN_SHR = 11;
  localparam int FIN_SHL_B = 15;

  // One byte step of the one-at-a-time hash.
  function automatic logic [HASH_W-1:0] oaat_mix(input logic [HASH_W-1:0] h_in,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] h;
    h = h_in + {{(HASH_W-8){1'b0}}, b};
    h = h + (h << MIX_SHL);
    h = h ^ (h >> MIX_SHR);
    return h;
  endfunction

  // Finalizing avalanche of the one-at-a-time hash.
  function automatic logic [HASH_W-1:0] oaat_final(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in + (h_in << FIN_SHL_A);
    h = h ^ (h >> FIN_SHR);
    h = h + (h << FIN_SHL_B);
    return h;
  endfunction

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] mixed_hash;
  logic              fin_valid;
  job_op_t           fin_op;
  logic [HASH_W-1:0] fin_hash;
  logic              accept;
  logic              fin_load;

  // Mix the incoming byte into the running hash.
  assign mixed_hash = req.has_byte ? oaat_mix(running_hash, req.data_byte) : running_hash;

  // The staging register frees up in the cycle it hands its job on.
  assign req_ready = !fin_valid || job_ready;
  assign accept    = req_valid && req_ready;

  // A finished key or a clear command loads the staging register.
  always_comb begin
    fin_load = 1'b0;
    if (accept) begin
      case (req.cmd) inside
        CMD_LOAD, CMD_QUERY: fin_load = req.last;
        CMD_CLEAR:           fin_load = 1'b1;
        default:             fin_load = 1'b0;
      endcase
    end
  end

  // Running hash and staging valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      fin_valid    <= 1'b0;
    end else begin
      if (fin_load) begin
        fin_valid <= 1'b1;
      end else if (job_ready) begin
        fin_valid <= 1'b0;
      end
      if (accept) begin
        case (req.cmd) inside
          CMD_LOAD, CMD_QUERY: running_hash <= req.last ? '0 : mixed_hash;
          CMD_CLEAR:           running_hash <= '0;
          default:             running_hash <= running_hash;
        endcase
      end
    end
  end

  // Staged operation and its unfinalized hash.
  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_hash <= (req.cmd == CMD_CLEAR) ? '0 : mixed_hash;
      case (req.cmd)
        CMD_LOAD:  fin_op <= OP_LOAD;
        CMD_QUERY: fin_op <= OP_QUERY;
        default:   fin_op <= OP_CLEAR;
      endcase
    end
  end

  // The finalizing step runs on the way into the queue.
  assign job_valid = fin_valid;
  assign job.op    = fin_op;
  assign job.hash  = oaat_final(fin_hash);

endmodule

FILE: rtl/core/hklt_queue.sv
module hklt_queue
  import hklt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/core/hklt_back.sv
module hklt_back
  import hklt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  entry_count;
  logic [HASH_W-1:0] query_hash;
  logic [CNT_W-1:0]  issue_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic              take;

  logic [HASH_W-1:0] table_mem [TABLE_DEPTH];
  logic [HASH_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;

  // A job starts only with the response register empty.
  assign job_ready = (state == S_IDLE) && !rsp_valid;
  assign take      = job_valid && job_ready;
  assign wr_en     = take && (job.op == OP_LOAD) && (entry_count < CNT_W'(TABLE_DEPTH));
  assign rd_addr   = issue_idx[IDX_W-1:0];

  // Table storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[entry_count[IDX_W-1:0]] <= job.hash;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= table_mem[rd_addr];
  end

  // Job sequencer and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
      issue_idx   <= '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (job.op)
              OP_CLEAR: begin
                entry_count     <= '0;
                rsp.kind        <= KIND_CLEAR;
                rsp.hit         <= 1'b0;
                rsp.entry_index <= '0;
                rsp.key_hash    <= '0;
                rsp.table_full  <= 1'b0;
                rsp_valid       <= 1'b1;
              end
              OP_LOAD: begin
                rsp.kind     <= KIND_LOAD;
                rsp.hit      <= 1'b0;
                rsp.key_hash <= job.hash;
                rsp_valid    <= 1'b1;
                if (entry_count < CNT_W'(TABLE_DEPTH)) begin
                  rsp.entry_index <= ENTRY_W'(entry_count);
                  rsp.table_full  <= 1'b0;
                  entry_count     <= entry_count + 1'b1;
                end else begin
                  rsp.entry_index <= '0;
                  rsp.table_full  <= 1'b1;
                end
              end
              OP_QUERY: begin
                rsp.kind        <= KIND_QUERY;
                rsp.hit         <= 1'b0;
                rsp.entry_index <= '0;
                rsp.key_hash    <= job.hash;
                rsp.table_full  <= 1'b0;
                if (entry_count == '0) begin
                  rsp_valid <= 1'b1;
                end else begin
                  query_hash <= job.hash;
                  issue_idx  <= '0;
                  cmp_valid  <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // Compare the entry read last cycle while the next read goes out.
          if (cmp_valid && (rd_data == query_hash)) begin
            rsp.hit         <= 1'b1;
            rsp.entry_index <= ENTRY_W'(cmp_idx);
            rsp_valid       <= 1'b1;
            cmp_valid       <= 1'b0;
            state           <= S_IDLE;
          end else if (cmp_valid && (cmp_idx == IDX_W'(entry_count - 1'b1))) begin
            rsp_valid <= 1'b1;
            cmp_valid <= 1'b0;
            state     <= S_IDLE;
          end else if (issue_idx < entry_count) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= issue_idx[IDX_W-1:0];
            issue_idx <= issue_idx + 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Only a query answer can report a hit.
  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> (rsp.kind == KIND_QUERY))
    else $error("hit flagged on a non-query response");

  // A dropped load means the table really is full.
  a_full_state: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.table_full) |-> (entry_count == CNT_W'(TABLE_DEPTH)))
    else $error("table_full reported with room left");

  // A search never runs with a response still pending.
  a_scan_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !rsp_valid)
    else $error("search running while a response is pending");

  // Every compare, and so every hit, is on an entry that has been loaded.
  a_hit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cmp_valid) |-> ({1'b0, cmp_idx} < {1'b0, entry_count}))
    else $error("compare on an entry beyond the fill count");

endmodule

FILE: rtl/core/hash_keyed_lookup_table.sv
// Channel   Signals                          Word
// request   req_valid / req_ready / req      cmd, data_byte, has_byte, last
// response  rsp_valid / rsp_ready / rsp      kind, hit, entry_index, key_hash, table_full
//
// Key bytes are taken one per cycle while the staging register can move on; a finished
// key or a clear is staged in a register and then queued (two entries) for the table engine.
// Load and clear are answered straight from the idle state; a query walks the table
// memory through its single read port, one entry per cycle.
// The engine takes its next job in the cycle after its response word is accepted.
// Reset clears the running hash, the queue and the fill count; table contents stay.
// A stalled response holds the engine, while the front keeps hashing until the queue fills.
module hash_keyed_lookup_table
  import hklt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  logic fj_valid;
  logic fj_ready;
  job_t fj;
  logic bj_valid;
  logic bj_ready;
  job_t bj;

  // Hashing front end.
  hklt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  // Job queue between front and back.
  hklt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_job   (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_job    (bj)
  );

  // Table engine.
  hklt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job       (bj),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: sim/hash_keyed_lookup_table_checker.sv
module hash_keyed_lookup_table_checker
  import hklt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  req_word_t req,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  rsp_word_t rsp,
  output int        errors,
  output int        pending,
  output int        loads_done,
  output int        loads_dropped,
  output int        query_hits,
  output int        query_misses,
  output int        clears_done
);

  // Shadow copy of the block's state.
  logic [HASH_W-1:0] key_acc;
  logic [HASH_W-1:0] stored_hash [TABLE_DEPTH];
  int                fill;

  // Response words still owed by the block, oldest first.
  rsp_word_t         predicted_rsp [$];

  int err_n   = 0;
  int load_n  = 0;
  int drop_n  = 0;
  int hit_n   = 0;
  int miss_n  = 0;
  int clear_n = 0;

  // One byte step of the one-at-a-time hash.
  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] t;
    t = h + HASH_W'(b);
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  // Avalanche applied once the key is complete.
  function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h;
    t = t + (t << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

  // Advance the shadow state by one accepted request word.
  task automatic apply_request(input req_word_t w);
    rsp_word_t         e;
    logic [HASH_W-1:0] h;
    bit                found;
    e = '0;
    case (w.cmd) inside
      CMD_CLEAR: begin
        fill = 0;
        key_acc = '0;
        e.kind = KIND_CLEAR;
        predicted_rsp.insert(predicted_rsp.size(), e);
      end
      CMD_LOAD, CMD_QUERY: begin
        if (w.has_byte) key_acc = mix_byte(key_acc, w.data_byte);
        if (w.last) begin
          h = finish_hash(key_acc);
          key_acc = '0;
          e.key_hash = h;
          if (w.cmd == CMD_LOAD) begin
            e.kind = KIND_LOAD;
            if (fill < TABLE_DEPTH) begin
              stored_hash[IDX_W'(fill)] = h;
              e.entry_index = ENTRY_W'(fill);
              fill++;
            end else begin
              e.table_full = 1'b1;
            end
          end else begin
            // Linear search from index zero; the first equal entry wins.
            e.kind = KIND_QUERY;
            found = 1'b0;
            for (int i = 0; i < fill && !found; i++) begin
              if (stored_hash[IDX_W'(i)] == h) begin
                found = 1'b1;
                e.hit = 1'b1;
                e.entry_index = ENTRY_W'(i);
              end
            end
          end
          predicted_rsp.insert(predicted_rsp.size(), e);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_field(input string name, input logic [HASH_W-1:0] want,
                              input logic [HASH_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_n++;
    end
  endtask

  // Responses are matched before requests, since a word accepted at this
  // edge cannot already have its answer on the response side.
  always @(posedge clk) begin : track
    rsp_word_t e;
    if (rst) begin
      key_acc = '0;
      fill = 0;
      predicted_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp.size() == 0) begin
          $display("%0t: response word with none expected, actual kind %0h hash %0h",
                   $time, rsp.kind, rsp.key_hash);
          err_n++;
        end else begin
          e = predicted_rsp.pop_front();
          report_field("kind", HASH_W'(e.kind), HASH_W'(rsp.kind));
          report_field("hit", HASH_W'(e.hit), HASH_W'(rsp.hit));
          report_field("entry_index", HASH_W'(e.entry_index), HASH_W'(rsp.entry_index));
          report_field("key_hash", e.key_hash, rsp.key_hash);
          report_field("table_full", HASH_W'(e.table_full), HASH_W'(rsp.table_full));
          case (e.kind)
            KIND_LOAD:  if (e.table_full) drop_n++; else load_n++;
            KIND_QUERY: if (e.hit) hit_n++; else miss_n++;
            KIND_CLEAR: clear_n++;
            default: ;
          endcase
        end
      end
      if (req_valid && req_ready) apply_request(req);
    end
    errors        <= err_n;
    pending       <= predicted_rsp.size();
    loads_done    <= load_n;
    loads_dropped <= drop_n;
    query_hits    <= hit_n;
    query_misses  <= miss_n;
    clears_done   <= clear_n;
  end

endmodule

FILE: sim/hash_keyed_lookup_table_tb.sv
module hash_keyed_lookup_table_tb;
  import hklt_pkg::*;

  // The package leaves the fourth command code unnamed; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1200;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD    = 400;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  int errors;
  int pending;
  int loads_done;
  int loads_dropped;
  int query_hits;
  int query_misses;
  int clears_done;

  int words_sent  = 0;
  int idle_cycles = 0;

  // Keys loaded since the last clear, kept so queries can be aimed at them.
  bit [63:0] kept_bytes [$];
  int        kept_len [$];
  int        loads_since_clear = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hash_keyed_lookup_table dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  hash_keyed_lookup_table_checker lookup_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .errors       (errors),
    .pending      (pending),
    .loads_done   (loads_done),
    .loads_dropped(loads_dropped),
    .query_hits   (query_hits),
    .query_misses (query_misses),
    .clears_done  (clears_done)
  );

  // Offer one request word and hold it until accepted. Bursts without idling
  // alternate with random gaps.
  task automatic put_word(input logic [1:0] cmd, input logic [7:0] data,
                          input logic has, input logic is_last);
    int        gap;
    req_word_t w;
    w.cmd = cmd;
    w.data_byte = data;
    w.has_byte = has;
    w.last = is_last;
    gap = ((words_sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  // Send a whole key. Inner bytes sometimes carry the other command and stray
  // words are mixed in; only the command on the last byte decides the outcome.
  task automatic send_key(input logic [1:0] fin_cmd, input bit [63:0] bytes, input int len);
    logic [1:0] cmd;
    if (len == 0) put_word(fin_cmd, 8'($urandom), 1'b0, 1'b1);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 39))
        0: put_word(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
        1: put_word(fin_cmd, 8'($urandom), 1'b0, 1'b0);
        default: ;
      endcase
      if (i < len - 1 && $urandom_range(0, 4) == 0)
        cmd = (fin_cmd == CMD_LOAD) ? CMD_QUERY : CMD_LOAD;
      else
        cmd = fin_cmd;
      put_word(cmd, bytes[8*i +: 8], 1'b1, i == len - 1);
    end
  endtask

  // Mostly short keys, so the table fills within the run.
  task automatic new_key(output bit [63:0] bytes, output int len);
    int r;
    r = $urandom_range(0, 99);
    bytes = {$urandom, $urandom};
    if (r < 5) len = 0;
    else if (r < 50) len = 1;
    else if (r < 75) len = 2;
    else len = $urandom_range(3, 8);
  endtask

  task automatic clear_table();
    put_word(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
    kept_bytes.delete();
    kept_len.delete();
    loads_since_clear = 0;
  endtask

  // Stop offering words until every predicted response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Response side: random stalls, stretches without stalls, and two long
  // holds that back the block up into its request side.
  initial begin : receiver
    int got;
    int gap;
    got = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (got == 120 || got == 350) gap = LONG_HOLD;
      else if ((got / 40) % 3 == 2) gap = 0;
      else gap = $urandom_range(0, 10);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      got++;
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    bit [63:0] bytes;
    int        len;
    int        pick;
    int        r;
    int        load_share;
    int        target;
    bit        paused;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, empty key, zero and all-ones bytes, mixed commands,
    // duplicate keys, ignored command, idle bytes, and a clear in mid-key.
    put_word(CMD_QUERY, 8'h00, 1'b1, 1'b1);
    put_word(CMD_LOAD, 8'hC3, 1'b0, 1'b1);
    put_word(CMD_LOAD, 8'h00, 1'b1, 1'b1);
    put_word(CMD_LOAD, 8'hFF, 1'b1, 1'b1);
    put_word(CMD_QUERY, 8'h5A, 1'b1, 1'b0);
    put_word(CMD_LOAD, 8'hA5, 1'b1, 1'b1);
    put_word(CMD_LOAD, 8'h5A, 1'b1, 1'b0);
    put_word(CMD_QUERY, 8'hA5, 1'b1, 1'b1);
    put_word(CMD_QUERY, 8'h3C, 1'b0, 1'b1);
    put_word(CMD_LOAD, 8'hFF, 1'b1, 1'b1);
    put_word(CMD_QUERY, 8'hFF, 1'b1, 1'b1);
    put_word(CMD_QUERY, 8'h41, 1'b1, 1'b1);
    put_word(CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
    put_word(CMD_LOAD, 8'h00, 1'b0, 1'b0);
    put_word(CMD_LOAD, 8'h33, 1'b1, 1'b1);
    put_word(CMD_LOAD, 8'h12, 1'b1, 1'b0);
    put_word(CMD_CLEAR, 8'hFF, 1'b1, 1'b1);
    put_word(CMD_QUERY, 8'h00, 1'b1, 1'b1);
    put_word(CMD_LOAD, 8'h12, 1'b1, 1'b1);
    put_word(CMD_CLEAR, 8'h00, 1'b0, 1'b0);
    wait_drained();

    // Random: load-heavy until the table overflows, then a mix of loads,
    // queries for stored and fresh keys, stray words, and clears.
    target = words_sent + RANDOM_WORDS;
    paused = 1'b0;
    while (words_sent < target) begin
      if (!paused && words_sent >= target - RANDOM_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      new_key(bytes, len);
      r = $urandom_range(0, 99);
      load_share = (loads_since_clear < 260) ? 80 : 45;
      if (loads_since_clear > 280 && r < 10) begin
        // Half of the clears cut a key off before its last byte.
        if (r < 5) begin
          for (int i = 0; i < len; i++)
            put_word(($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_QUERY,
                     bytes[8*i +: 8], 1'b1, 1'b0);
        end
        clear_table();
      end else if (r < load_share) begin
        if (kept_len.size() > 0 && $urandom_range(0, 9) == 0) begin
          pick = $urandom_range(0, kept_len.size() - 1);
          bytes = kept_bytes[pick];
          len = kept_len[pick];
        end
        send_key(CMD_LOAD, bytes, len);
        kept_bytes.insert(kept_bytes.size(), bytes);
        kept_len.insert(kept_len.size(), len);
        loads_since_clear++;
      end else if (r < load_share + (100 - load_share) / 2 && kept_len.size() > 0) begin
        pick = $urandom_range(0, kept_len.size() - 1);
        send_key(CMD_QUERY, kept_bytes[pick], kept_len[pick]);
      end else if (r < 97) begin
        send_key(CMD_QUERY, bytes, len);
      end else begin
        put_word(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end

    // Let the last responses arrive, then watch for stray ones.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request words; %0d keys stored, %0d loads refused on a full table,",
             words_sent, loads_done, loads_dropped);
    $display("%0d query hits, %0d query misses and %0d clears checked, %0d mismatches.",
             query_hits, query_misses, clears_done, errors);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
